FILE: rtl/lge_pkg.sv
// Shared constants, types and codes of the life grid engine.
package lge_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;

  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam int FUNC_W    = 2;
  localparam int COORD_W   = 6;
  localparam int GEN_W     = 32;

  localparam int COL_IDX_W = $clog2(MAX_WIDTH);
  localparam int ROW_IDX_W = $clog2(MAX_HEIGHT);
  localparam int WCNT_W    = $clog2(MAX_WIDTH + 1);
  localparam int HCNT_W    = $clog2(MAX_HEIGHT + 1);

  localparam int NBR_W = 4;
  localparam logic [NBR_W-1:0] BIRTH_COUNT   = NBR_W'(3);
  localparam logic [NBR_W-1:0] SURVIVE_COUNT = NBR_W'(2);

  localparam logic [CFG_W-1:0] GRID_RESET = CFG_W'(64);

  typedef logic [MAX_WIDTH-1:0] row_t;
  typedef logic [ROW_IDX_W-1:0] row_addr_t;
  typedef logic [COL_IDX_W-1:0] col_addr_t;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_SET   = 2'd1,
    FUNC_STEP  = 2'd2,
    FUNC_READ  = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } reg_idx_t;

  // one port request to a row store
  typedef struct packed {
    logic      we;
    row_addr_t waddr;
    row_t      wdata;
    logic      re;
    row_addr_t raddr;
  } mem_req_t;

endpackage

FILE: rtl/lge_in_if.sv
// Command channel: one operation word per handshake.
interface lge_in_if import lge_pkg::*; ();
  logic                 valid;
  logic                 ready;
  func_t                func;
  logic [COORD_W-1:0]   col;
  logic [COORD_W-1:0]   row;
  logic                 new_value;

  modport source (output valid, func, col, row, new_value, input ready);
  modport sink   (input valid, func, col, row, new_value, output ready);
endinterface

FILE: rtl/lge_out_if.sv
// Response channel: one result word per handshake.
interface lge_out_if import lge_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               cell_value;
  logic               cell_changed;
  logic [GEN_W-1:0]   generation;

  modport source (output valid, cell_value, cell_changed, generation, input ready);
  modport sink   (input valid, cell_value, cell_changed, generation, output ready);
endinterface

FILE: rtl/life_grid_engine_top.sv
// Life grid engine top level: sequencer, double-buffered row stores, cell unit.
// A set or read outside the active size skips the row stores and goes straight to done;
//   a step primes the row window, then for every row of the store visits each cell and writes the row.
// Throughput: one word at a time; the next word is taken once the sequencer is back
//   in idle, even while the previous result still waits in the output reg.
// Reset: a clearing pass zeroes both row stores, no word accepted meanwhile.
module life_grid_engine_top import lge_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  lge_in_if.sink               cmd,
  lge_out_if.source            rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  typedef enum logic [11:0] {
    S_IDLE     = 12'b000000000001,
    S_CLEAR    = 12'b000000000010,
    S_SET_RD   = 12'b000000000100,
    S_SET_WR   = 12'b000000001000,
    S_READ_RD  = 12'b000000010000,
    S_READ_CAP = 12'b000000100000,
    S_PRIME0   = 12'b000001000000,
    S_PRIME1   = 12'b000010000000,
    S_PRIME2   = 12'b000100000000,
    S_CELL     = 12'b001000000000,
    S_ROWWR    = 12'b010000000000,
    S_DONE     = 12'b100000000000
  } state_t;

  state_t state, state_next;

  // configuration and control
  logic [CFG_W-1:0]  grid_width;
  logic [CFG_W-1:0]  grid_height;
  logic [WCNT_W-1:0] eff_w;
  logic [HCNT_W-1:0] eff_h;
  logic              current_select;
  logic [GEN_W-1:0]  gen_total;
  row_addr_t         row_cnt;
  col_addr_t         col_cnt;
  logic              clr_reply;
  logic              rsp_valid;

  // latched operation
  row_addr_t op_row;
  col_addr_t op_col;
  logic      op_val;
  logic      res_value;
  logic      res_changed;

  // step window: rows r-1, r, r+1 and the row under construction
  row_t up, mid, dn, out_row;
  row_t col_mask;
  row_t set_row;

  logic              cmd_fire;
  logic              cmd_inside;
  logic              rsp_load;
  logic              last_row;
  logic              last_col;
  logic [ROW_IDX_W:0] nr;
  logic              nr_ok;
  logic              nr_live;
  logic              cell_live;
  logic              rule_alive;

  mem_req_t req_cur, req_oth, req_a, req_b;
  row_t     rd_a, rd_b, cur_rd, oth_rd;

  // size registers clamp to 1..max; raw bits are kept
  always_comb begin
    if (grid_width == '0) begin
      eff_w = WCNT_W'(1);
    end else if (32'(grid_width) > 32'(MAX_WIDTH)) begin
      eff_w = WCNT_W'(MAX_WIDTH);
    end else begin
      eff_w = WCNT_W'(grid_width);
    end
    if (grid_height == '0) begin
      eff_h = HCNT_W'(1);
    end else if (32'(grid_height) > 32'(MAX_HEIGHT)) begin
      eff_h = HCNT_W'(MAX_HEIGHT);
    end else begin
      eff_h = HCNT_W'(grid_height);
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_WIDTH; i++) begin
      col_mask[i] = (32'(i) < 32'(eff_w));
    end
  end

  assign cmd.ready  = (state == S_IDLE);
  assign cmd_fire   = cmd.valid && cmd.ready;
  assign cmd_inside = (32'(cmd.col) < 32'(eff_w)) && (32'(cmd.row) < 32'(eff_h));
  assign rsp_load   = !rsp_valid || rsp.ready;

  assign last_row  = (row_cnt == ROW_IDX_W'(MAX_HEIGHT - 1));
  assign last_col  = (col_cnt == COL_IDX_W'(MAX_WIDTH - 1));
  assign nr        = {1'b0, row_cnt} + (ROW_IDX_W + 1)'(2);
  assign nr_ok     = (32'(nr) < 32'(MAX_HEIGHT));
  assign nr_live   = nr_ok && (32'(nr) < 32'(eff_h));
  assign cell_live = (32'(col_cnt) < 32'(eff_w)) && (32'(row_cnt) < 32'(eff_h));

  // buffer select maps current / other onto the two stores
  assign req_a  = current_select ? req_oth : req_cur;
  assign req_b  = current_select ? req_cur : req_oth;
  assign cur_rd = current_select ? rd_b : rd_a;
  assign oth_rd = current_select ? rd_a : rd_b;

  always_comb begin
    set_row         = cur_rd;
    set_row[op_col] = op_val;
  end

  lge_row_ram u_grid_a (.clk(clk), .req(req_a), .rd_data(rd_a));
  lge_row_ram u_grid_b (.clk(clk), .req(req_b), .rd_data(rd_b));

  lge_rule_unit u_rule (
    .up    (up),
    .mid   (mid),
    .dn    (dn),
    .col   (col_cnt),
    .live  (cell_live),
    .alive (rule_alive)
  );

  // sequencer and store port requests
  always_comb begin
    state_next = state;
    req_cur    = '0;
    req_oth    = '0;
    case (state)
      S_IDLE: begin
        if (cmd_fire) begin
          case (cmd.func)
            FUNC_CLEAR: state_next = S_CLEAR;
            FUNC_SET:   state_next = cmd_inside ? S_SET_RD : S_DONE;
            FUNC_STEP:  state_next = S_PRIME0;
            FUNC_READ:  state_next = cmd_inside ? S_READ_RD : S_DONE;
            default:    state_next = S_DONE;
          endcase
        end
      end
      S_CLEAR: begin
        // both stores zeroed one row a cycle
        req_cur.we    = 1'b1;
        req_cur.waddr = row_cnt;
        req_oth.we    = 1'b1;
        req_oth.waddr = row_cnt;
        if (last_row) begin
          state_next = clr_reply ? S_DONE : S_IDLE;
        end
      end
      S_SET_RD: begin
        req_cur.re    = 1'b1;
        req_cur.raddr = op_row;
        state_next    = S_SET_WR;
      end
      S_SET_WR: begin
        req_cur.we    = 1'b1;
        req_cur.waddr = op_row;
        req_cur.wdata = set_row;
        state_next    = S_DONE;
      end
      S_READ_RD: begin
        req_cur.re    = 1'b1;
        req_cur.raddr = op_row;
        req_oth.re    = 1'b1;
        req_oth.raddr = op_row;
        state_next    = S_READ_CAP;
      end
      S_READ_CAP: state_next = S_DONE;
      S_PRIME0: begin
        req_cur.re    = 1'b1;
        req_cur.raddr = '0;
        state_next    = S_PRIME1;
      end
      S_PRIME1: begin
        req_cur.re    = 1'b1;
        req_cur.raddr = ROW_IDX_W'(1);
        state_next    = S_PRIME2;
      end
      S_PRIME2: state_next = S_CELL;
      S_CELL: begin
        // fetch row r+2 early; it is held in the read register until row write
        if ((col_cnt == '0) && nr_ok) begin
          req_cur.re    = 1'b1;
          req_cur.raddr = nr[ROW_IDX_W-1:0];
        end
        if (last_col) begin
          state_next = S_ROWWR;
        end
      end
      S_ROWWR: begin
        req_oth.we    = 1'b1;
        req_oth.waddr = row_cnt;
        req_oth.wdata = out_row;
        state_next    = last_row ? S_DONE : S_CELL;
      end
      S_DONE: begin
        if (rsp_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      row_cnt        <= '0;
      col_cnt        <= '0;
      current_select <= 1'b0;
      gen_total      <= '0;
      grid_width     <= GRID_RESET;
      grid_height    <= GRID_RESET;
      rsp_valid      <= 1'b0;
      clr_reply      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_GRID_WIDTH:  grid_width  <= cfg_wdata;
          REG_GRID_HEIGHT: grid_height <= cfg_wdata;
          default: ;
        endcase
      end
      if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_fire) begin
            row_cnt   <= '0;
            col_cnt   <= '0;
            clr_reply <= 1'b1;
          end
        end
        S_CLEAR: begin
          row_cnt <= row_cnt + 1'b1;
          if (last_row) begin
            row_cnt        <= '0;
            current_select <= 1'b0;
            gen_total      <= '0;
          end
        end
        S_CELL: begin
          col_cnt <= last_col ? '0 : col_cnt + 1'b1;
        end
        S_ROWWR: begin
          if (last_row) begin
            row_cnt        <= '0;
            current_select <= ~current_select;
            gen_total      <= gen_total + 1'b1;
          end else begin
            row_cnt <= row_cnt + 1'b1;
          end
        end
        S_DONE: begin
          if (rsp_load) begin
            rsp_valid <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (cmd_fire) begin
          op_row      <= ROW_IDX_W'(cmd.row);
          op_col      <= COL_IDX_W'(cmd.col);
          op_val      <= cmd.new_value;
          res_value   <= 1'b0;
          res_changed <= 1'b0;
        end
      end
      S_READ_CAP: begin
        res_value   <= cur_rd[op_col];
        res_changed <= cur_rd[op_col] ^ oth_rd[op_col];
      end
      S_PRIME0: up <= '0;
      // row 0 is always active
      S_PRIME1: mid <= cur_rd & col_mask;
      S_PRIME2: dn <= (32'(1) < 32'(eff_h)) ? (cur_rd & col_mask) : '0;
      S_CELL:   out_row[col_cnt] <= rule_alive;
      S_ROWWR: begin
        up  <= mid;
        mid <= dn;
        dn  <= nr_live ? (cur_rd & col_mask) : '0;
      end
      S_DONE: begin
        if (rsp_load) begin
          rsp.cell_value   <= res_value;
          rsp.cell_changed <= res_changed;
          rsp.generation   <= gen_total;
        end
      end
      default: ;
    endcase
  end

  assign rsp.valid = rsp_valid;

  // only the clearing pass writes both stores in one cycle
  assert property (@(posedge clk) disable iff (rst)
    (req_a.we && req_b.we) |-> (state == S_CLEAR))
    else $error("both row stores written outside clearing pass");

  // a step row goes to the previous-generation store only
  assert property (@(posedge clk) disable iff (rst)
    (state == S_ROWWR) |->
      (current_select ? (req_a.we && !req_b.we) : (req_b.we && !req_a.we)))
    else $error("step row written to the current store");

  // generation moves only at the end of a step or a clear
  assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (gen_total != $past(gen_total))) |->
      ($past(state) == S_ROWWR || $past(state) == S_CLEAR))
    else $error("generation count changed outside step or clear");

  // a result appears only out of the done state
  assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $rose(rsp_valid)) |-> ($past(state) == S_DONE))
    else $error("result raised outside done state");

endmodule

FILE: rtl/lge_row_ram.sv
// Row store: one grid buffer, one row per entry, registered read.
module lge_row_ram import lge_pkg::*; (
  input  logic     clk,
  input  mem_req_t req,
  output row_t     rd_data
);

  row_t mem [MAX_HEIGHT];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
  end

endmodule

FILE: rtl/lge_rule_unit.sv
// Shared B3/S23 cell unit: neighbor count and next state of one cell.
module lge_rule_unit import lge_pkg::*; (
  input  row_t      up,
  input  row_t      mid,
  input  row_t      dn,
  input  col_addr_t col,
  input  logic      live,
  output logic      alive
);

  col_addr_t        col_l;
  col_addr_t        col_r;
  logic             l_ok;
  logic             r_ok;
  logic [NBR_W-1:0] cnt;

  assign col_l = col - 1'b1;
  assign col_r = col + 1'b1;
  assign l_ok  = (col != '0);
  assign r_ok  = (col != COL_IDX_W'(MAX_WIDTH - 1));

  // left and right edges of the store read as dead
  always_comb begin
    cnt = NBR_W'(up[col]) + NBR_W'(dn[col]);
    if (l_ok) begin
      cnt = cnt + NBR_W'(up[col_l]) + NBR_W'(mid[col_l]) + NBR_W'(dn[col_l]);
    end
    if (r_ok) begin
      cnt = cnt + NBR_W'(up[col_r]) + NBR_W'(mid[col_r]) + NBR_W'(dn[col_r]);
    end
  end

  assign alive = live && ((cnt == BIRTH_COUNT) || ((cnt == SURVIVE_COUNT) && mid[col]));

endmodule

FILE: dv/life_grid_checker.sv
// Checker for the life grid engine: predicts every response word and compares.
`timescale 1ns / 1ps

module life_grid_checker import lge_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  lge_in_if                    cmd_mon,
  lge_out_if                   rsp_mon,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   mismatches,
  output int                   pending
);

  localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;

  typedef struct {
    logic             cell_value;
    logic             cell_changed;
    logic [GEN_W-1:0] generation;
  } cell_rsp_t;

  // shadow copy of the engine state
  bit [CELLS-1:0]   plane [2];
  bit               live_plane;
  logic [GEN_W-1:0] gen_total;
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;

  cell_rsp_t awaited_rsp [$];
  int        bad = 0;

  // 0 acts as 1, anything above the built size acts as the built size
  function automatic int active_dim(logic [CFG_W-1:0] raw, int maxv);
    if (raw == '0) return 1;
    if (int'(raw) > maxv) return maxv;
    return int'(raw);
  endfunction

  task automatic advance_generation();
    int w, h;
    w = active_dim(width_reg, MAX_WIDTH);
    h = active_dim(height_reg, MAX_HEIGHT);
    for (int r = 0; r < MAX_HEIGHT; r++) begin
      for (int c = 0; c < MAX_WIDTH; c++) begin
        int n;
        bit nv;
        n  = 0;
        nv = 1'b0;
        if (c < w && r < h) begin
          for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
              if ((dr != 0 || dc != 0) && r + dr >= 0 && r + dr < h &&
                  c + dc >= 0 && c + dc < w) begin
                n += plane[live_plane][(r + dr) * MAX_WIDTH + c + dc];
              end
            end
          end
          if (n == int'(BIRTH_COUNT)) nv = 1'b1;
          else if (n == int'(SURVIVE_COUNT)) nv = plane[live_plane][r * MAX_WIDTH + c];
        end
        plane[~live_plane][r * MAX_WIDTH + c] = nv;
      end
    end
    live_plane = ~live_plane;
    gen_total  = gen_total + 1'b1;
  endtask

  task automatic predict_word(func_t f, logic [COORD_W-1:0] col, logic [COORD_W-1:0] row,
                              logic nv);
    cell_rsp_t e;
    bit        in_area;
    int        idx;
    in_area = int'(col) < active_dim(width_reg, MAX_WIDTH) &&
              int'(row) < active_dim(height_reg, MAX_HEIGHT);
    idx = int'(row) * MAX_WIDTH + int'(col);
    e.cell_value   = 1'b0;
    e.cell_changed = 1'b0;
    case (f)
      FUNC_CLEAR: begin
        plane[0]   = '0;
        plane[1]   = '0;
        live_plane = 1'b0;
        gen_total  = '0;
      end
      FUNC_SET: begin
        if (in_area) plane[live_plane][idx] = nv;
      end
      FUNC_STEP: begin
        advance_generation();
      end
      FUNC_READ: begin
        if (in_area) begin
          e.cell_value   = plane[live_plane][idx];
          e.cell_changed = plane[live_plane][idx] ^ plane[~live_plane][idx];
        end
      end
      default: ;
    endcase
    e.generation = gen_total;
    awaited_rsp.push_back(e);
  endtask

  always @(posedge clk) begin
    cell_rsp_t e;
    if (rst) begin
      plane[0]   = '0;
      plane[1]   = '0;
      live_plane = 1'b0;
      gen_total  = '0;
      width_reg  = GRID_RESET;
      height_reg = GRID_RESET;
      awaited_rsp.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_GRID_WIDTH) width_reg = cfg_wdata;
        else height_reg = cfg_wdata;
      end
      // response first: it always belongs to an older word
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (awaited_rsp.size() == 0) begin
          $error("response word with no command waiting");
          bad++;
        end else begin
          e = awaited_rsp.pop_front();
          if (rsp_mon.cell_value !== e.cell_value) begin
            $error("cell_value: expected %0d, actual %0d", e.cell_value, rsp_mon.cell_value);
            bad++;
          end
          if (rsp_mon.cell_changed !== e.cell_changed) begin
            $error("cell_changed: expected %0d, actual %0d",
                   e.cell_changed, rsp_mon.cell_changed);
            bad++;
          end
          if (rsp_mon.generation !== e.generation) begin
            $error("generation: expected %0d, actual %0d", e.generation, rsp_mon.generation);
            bad++;
          end
        end
      end
      if (cmd_mon.valid && cmd_mon.ready) begin
        predict_word(cmd_mon.func, cmd_mon.col, cmd_mon.row, cmd_mon.new_value);
      end
    end
    mismatches <= bad;
    pending    <= awaited_rsp.size();
  end

endmodule

FILE: dv/tb_life_grid_engine_top.sv
// Testbench top for the life grid engine: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps

module tb_life_grid_engine_top;
  import lge_pkg::*;

  // longer than a step or the long hold-off; nothing legal idles this long
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = 40;
  // long receiver hold-off lands early in the first random phase
  localparam int HOLD_AT        = 30;
  localparam int LONG_HOLD      = 400;
  localparam int RANDOM_PHASES  = 5;
  localparam int PHASE_WORDS    = 23;

  typedef enum int {RDY_OPEN, RDY_COIN, RDY_TIGHT} rdy_mode_t;

  logic clk = 1'b0;
  logic rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  int mismatches;
  int pending;
  int words_sent  = 0;
  int idle_cycles = 0;
  int burst_left  = 0;
  // active size as the stimulus sees it, to aim coordinates
  int act_w = MAX_WIDTH;
  int act_h = MAX_HEIGHT;

  lge_in_if  cmd_if ();
  lge_out_if rsp_if ();

  life_grid_engine_top dut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_if),
    .rsp       (rsp_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  life_grid_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .cmd_mon    (cmd_if),
    .rsp_mon    (rsp_if),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // word count for the hold-off trigger, plus the no-progress watchdog
  always @(posedge clk) begin
    if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (cmd_if.valid && cmd_if.ready) words_sent <= words_sent + 1;
  end

  // Receiver: segments of open, coin-flip or tight ready, and one long
  // hold-off while the sender keeps offering, so the engine backs up.
  initial begin
    rdy_mode_t mode;
    int        seg_left;
    bit        hold_done;
    mode      = RDY_OPEN;
    seg_left  = 0;
    hold_done = 1'b0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && words_sent >= HOLD_AT) begin
        hold_done = 1'b1;
        rsp_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else begin
        if (seg_left == 0) begin
          case ($urandom_range(0, 2))
            0:       mode = RDY_OPEN;
            1:       mode = RDY_COIN;
            default: mode = RDY_TIGHT;
          endcase
          seg_left = $urandom_range(8, 64);
        end
        seg_left--;
        case (mode)
          RDY_OPEN:  rsp_if.ready <= 1'b1;
          RDY_COIN:  rsp_if.ready <= 1'($urandom_range(0, 1));
          RDY_TIGHT: rsp_if.ready <= ($urandom_range(0, 3) == 0);
          default:   rsp_if.ready <= 1'b1;
        endcase
      end
    end
  end

  // Offer one word and hold it until taken. Words go out in bursts; at the
  // end of a burst valid drops for a random gap (sometimes a long one).
  task automatic send_word(func_t f, int c, int r, bit v);
    int gap;
    cmd_if.valid     <= 1'b1;
    cmd_if.func      <= f;
    cmd_if.col       <= COORD_W'(c);
    cmd_if.row       <= COORD_W'(r);
    cmd_if.new_value <= v;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 6);
      cmd_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  // Sender pauses until every response is back; the engine is idle after.
  task automatic settle();
    cmd_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Both size registers, back to back; only called while idle.
  task automatic set_size(int w, int h);
    cfg_we    <= 1'b1;
    cfg_index <= REG_GRID_WIDTH;
    cfg_wdata <= CFG_W'(w);
    @(negedge clk);
    cfg_index <= REG_GRID_HEIGHT;
    cfg_wdata <= CFG_W'(h);
    @(negedge clk);
    cfg_we <= 1'b0;
    act_w = (w == 0) ? 1 : (w > MAX_WIDTH) ? MAX_WIDTH : w;
    act_h = (h == 0) ? 1 : (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
  endtask

  // Sets lead, inside the active area, with steps and reads between them,
  // so patterns actually evolve; some coordinates stray past the border,
  // and the odd clear restarts the count.
  task automatic random_phase(int n);
    int    pick, c, r;
    func_t f;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 6)       f = FUNC_CLEAR;
      else if (pick < 48) f = FUNC_SET;
      else if (pick < 63) f = FUNC_STEP;
      else                f = FUNC_READ;
      if ($urandom_range(0, 4) != 0) begin
        c = $urandom_range(0, act_w - 1);
        r = $urandom_range(0, act_h - 1);
      end else begin
        c = $urandom_range(0, 63);
        r = $urandom_range(0, 63);
      end
      send_word(f, c, r, $urandom_range(0, 9) < 7);
    end
  endtask

  initial begin
    int w, h;
    rst              = 1'b1;
    cmd_if.valid     = 1'b0;
    cmd_if.func      = FUNC_CLEAR;
    cmd_if.col       = '0;
    cmd_if.row       = '0;
    cmd_if.new_value = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = REG_GRID_WIDTH;
    cfg_wdata        = '0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // Directed, reset size 64 x 64. The engine runs its clearing pass first;
    // the first word just waits for ready.
    send_word(FUNC_CLEAR, 0, 0, 1'b0);
    // L in the top-left corner: fills to a block in the corner
    send_word(FUNC_SET, 0, 0, 1'b1);
    send_word(FUNC_SET, 1, 0, 1'b1);
    send_word(FUNC_SET, 0, 1, 1'b1);
    // blinker lying on the bottom edge, far corner included
    send_word(FUNC_SET, 63, 63, 1'b1);
    send_word(FUNC_SET, 62, 63, 1'b1);
    send_word(FUNC_SET, 61, 63, 1'b1);
    // set then kill a lone cell
    send_word(FUNC_SET, 63, 0, 1'b1);
    send_word(FUNC_SET, 63, 0, 1'b0);
    // changed flag before any step compares against the zeroed buffer
    send_word(FUNC_READ, 63, 63, 1'b0);
    send_word(FUNC_READ, 63, 0, 1'b0);
    send_word(FUNC_STEP, 0, 0, 1'b0);
    send_word(FUNC_READ, 1, 1, 1'b0);
    send_word(FUNC_READ, 62, 62, 1'b0);
    send_word(FUNC_READ, 63, 63, 1'b0);
    send_word(FUNC_STEP, 63, 63, 1'b1);
    send_word(FUNC_READ, 62, 63, 1'b1);
    settle();

    // Width 0 acts as 1, height 127 as the maximum; no clear, old cells stay.
    set_size(0, 127);
    send_word(FUNC_SET, 5, 5, 1'b1);
    send_word(FUNC_READ, 5, 5, 1'b0);
    send_word(FUNC_SET, 0, 40, 1'b1);
    send_word(FUNC_SET, 0, 41, 1'b1);
    send_word(FUNC_SET, 0, 42, 1'b1);
    send_word(FUNC_STEP, 0, 0, 1'b0);
    send_word(FUNC_READ, 0, 41, 1'b0);
    send_word(FUNC_READ, 0, 40, 1'b0);
    settle();

    // Random phases: a few fixed extremes, then mostly small grids.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin w = 127; h = 0; end
        1: begin w = 1;   h = 1; end
        2: begin w = 64;  h = 64; end
        default: begin
          if ($urandom_range(0, 3) == 0) begin
            w = $urandom_range(0, 127);
            h = $urandom_range(0, 127);
          end else begin
            w = $urandom_range(2, 12);
            h = $urandom_range(2, 12);
          end
        end
      endcase
      set_size(w, h);
      random_phase(PHASE_WORDS);
      settle();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
